[design/bir_pkg.sv]
`timescale 1ns / 1ps

package bir_pkg;

    // Field widths of one transaction
    localparam int SRC_COORD_W = 8;
    localparam int DST_COORD_W = 12;
    localparam int PIX_W       = 32;
    localparam int CH_N        = 4;
    localparam int CH_W        = 8;

    // Configuration register widths and derived arithmetic widths
    localparam int SRC_CFG_W = 9;
    localparam int TGT_CFG_W = 13;
    localparam int DEN_W     = TGT_CFG_W + 1;
    localparam int ODD_W     = DST_COORD_W + 1;
    localparam int PROD_W    = 2 * DEN_W;
    localparam int TOP_W     = CH_W + DEN_W;
    localparam int ACC_W     = CH_W + PROD_W;

    localparam logic [SRC_CFG_W-1:0] SRC_CFG_RST = SRC_CFG_W'(256);
    localparam logic [TGT_CFG_W-1:0] TGT_CFG_RST = TGT_CFG_W'(256);

    // Register port
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int REG_LSB = 2;

    localparam int MAX_SRC_WIDTH_DEF  = 256;
    localparam int MAX_SRC_HEIGHT_DEF = 256;

    typedef logic [SRC_COORD_W-1:0] t_src_coord;
    typedef logic [DST_COORD_W-1:0] t_dst_coord;
    typedef logic [PIX_W-1:0]       t_pixel;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_TGT_WIDTH  = 2'd2,
        REG_TGT_HEIGHT = 2'd3
    } t_reg_idx;

endpackage

[design/bir_in_if.sv]
`timescale 1ns / 1ps

interface bir_in_if;
    logic                valid;
    logic                ready;
    bir_pkg::t_action    action;
    bir_pkg::t_src_coord src_col;
    bir_pkg::t_src_coord src_row;
    bir_pkg::t_pixel     src_pixel;
    bir_pkg::t_dst_coord dst_col;
    bir_pkg::t_dst_coord dst_row;

    modport source (
        output valid, action, src_col, src_row, src_pixel, dst_col, dst_row,
        input  ready
    );
    modport sink (
        input  valid, action, src_col, src_row, src_pixel, dst_col, dst_row,
        output ready
    );
endinterface

[design/bir_out_if.sv]
`timescale 1ns / 1ps

interface bir_out_if;
    logic            valid;
    logic            ready;
    bir_pkg::t_pixel out_pixel;
    logic            out_of_range;

    modport source (
        output valid, out_pixel, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, out_pixel, out_of_range,
        output ready
    );
endinterface

[design/bir_ram.sv]
`timescale 1ns / 1ps

module bir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the read word while the pipeline is stalled
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bilinear_image_resampler.sv]
`timescale 1ns / 1ps

// Bilinear resampler with half-pixel centres over a stored BGRA source frame.
// A load transaction writes one source pixel (ignored when outside the source
// size); a sample transaction returns one interpolated pixel, or zero with
// out_of_range set when the destination coordinate lies outside the target
// size. The block takes one transaction every clock unless the output stalls;
// the coordinate division retires one quotient bit per stage for NDIV
// quotient bits, where NDIV is the larger of the column and row address widths
// (at least 2), and the final per-channel normalisation retires one result bit
// per stage over eight stages. The frame sits in four single-port-read banks
// split by column and row parity, so the four neighbours are read in the same
// cycle. The whole pipeline advances together and stalls only while a finished
// result waits at the output. Configuration is to be written by the user over
// the register port only while the block is idle; the block itself does not
// enforce this. No clearing pass runs after reset and unwritten pixels read as
// whatever the memory holds.
module bilinear_image_resampler #(
    parameter int MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bir_in_if.sink                     i_in,
    bir_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bir_pkg::APB_AW-1:0] paddr,
    input  logic [bir_pkg::APB_DW-1:0] pwdata,
    output logic [bir_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import bir_pkg::*;

    // Address and coordinate widths follow the maximum frame size
    localparam int XB   = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
    localparam int YB   = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int XP   = (XB > 2) ? XB : 2;
    localparam int YP   = (YB > 2) ? YB : 2;
    localparam int SXW  = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SYW  = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int NDIV = (XP > YP) ? XP : YP;
    localparam int NXW  = ODD_W + SXW;
    localparam int NYW  = ODD_W + SYW;
    localparam int TXW  = SXW + DEN_W;
    localparam int TYW  = SYW + DEN_W;
    localparam int DXW  = (NXW > DEN_W + NDIV) ? NXW : DEN_W + NDIV;
    localparam int DYW  = (NYW > DEN_W + NDIV) ? NYW : DEN_W + NDIV;
    localparam int BAW  = (XP - 1) + (YP - 1);
    localparam int BANK_DEPTH = 1 << BAW;
    localparam int BANK_N = 4;

    typedef logic [XP-1:0] t_xc;
    typedef logic [YP-1:0] t_yc;

    // Input stage register: range checks and coordinate products
    typedef struct packed {
        logic           vld;
        logic           smp;
        logic           oor;
        logic           ldok;
        t_xc            col;
        t_yc            row;
        t_pixel         pix;
        logic [NXW-1:0] ax;
        logic [NYW-1:0] ay;
    } t_p1;

    // Clamped numerators and the coordinate division in flight
    typedef struct packed {
        logic            vld;
        logic            smp;
        logic            oor;
        logic            ldok;
        t_xc             col;
        t_yc             row;
        t_pixel          pix;
        logic [NXW-1:0]  remx;
        logic [NDIV-1:0] qx;
        logic [NYW-1:0]  remy;
        logic [NDIV-1:0] qy;
    } t_dv;

    // Alongside the bank read
    typedef struct packed {
        logic             vld;
        logic             smp;
        logic             oor;
        logic             x0p;
        logic             x1p;
        logic             y0p;
        logic             y1p;
        logic [DEN_W-1:0] fx;
        logic [DEN_W-1:0] fy;
    } t_pr;

    // Horizontal blend per channel
    typedef struct packed {
        logic                        vld;
        logic                        smp;
        logic                        oor;
        logic [DEN_W-1:0]            fy;
        logic [CH_N-1:0][TOP_W-1:0]  top;
        logic [CH_N-1:0][TOP_W-1:0]  bot;
    } t_pw;

    // Normalising division per channel
    typedef struct packed {
        logic                        vld;
        logic                        smp;
        logic                        oor;
        logic [CH_N-1:0][ACC_W-1:0]  rem;
        logic [CH_N-1:0][CH_W-1:0]   q;
    } t_ea;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SRC_CFG_W-1:0] r_src_w;
    logic [SRC_CFG_W-1:0] r_src_h;
    logic [TGT_CFG_W-1:0] r_tgt_w;
    logic [TGT_CFG_W-1:0] r_tgt_h;
    logic                 cfg_wr;
    t_reg_idx             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[REG_LSB+1:REG_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_CFG_RST;
            r_src_h <= SRC_CFG_RST;
            r_tgt_w <= TGT_CFG_RST;
            r_tgt_h <= TGT_CFG_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  r_src_w <= pwdata[SRC_CFG_W-1:0];
                REG_SRC_HEIGHT: r_src_h <= pwdata[SRC_CFG_W-1:0];
                REG_TGT_WIDTH:  r_tgt_w <= pwdata[TGT_CFG_W-1:0];
                REG_TGT_HEIGHT: r_tgt_h <= pwdata[TGT_CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = APB_DW'(r_src_w);
            REG_SRC_HEIGHT: prdata = APB_DW'(r_src_h);
            REG_TGT_WIDTH:  prdata = APB_DW'(r_tgt_w);
            REG_TGT_HEIGHT: prdata = APB_DW'(r_tgt_h);
        endcase
    end

    // Effective source size: zero acts as one, oversize saturates
    logic [SXW-1:0] n_sw;
    logic [SYW-1:0] n_sh;

    always_comb begin
        if (r_src_w == '0) begin
            n_sw = SXW'(1);
        end else if (int'(r_src_w) > MAX_SRC_WIDTH) begin
            n_sw = SXW'(MAX_SRC_WIDTH);
        end else begin
            n_sw = SXW'(r_src_w);
        end
        if (r_src_h == '0) begin
            n_sh = SYW'(1);
        end else if (int'(r_src_h) > MAX_SRC_HEIGHT) begin
            n_sh = SYW'(MAX_SRC_HEIGHT);
        end else begin
            n_sh = SYW'(r_src_h);
        end
    end

    // Constants derived from configuration, refreshed every cycle. Later
    // stages read these; the first stage reads the effective sizes directly.
    logic [SXW-1:0]    r_sw;
    logic [SYW-1:0]    r_sh;
    logic [DEN_W-1:0]  r_dnx;
    logic [DEN_W-1:0]  r_dny;
    logic [TXW-1:0]    r_topx;
    logic [TYW-1:0]    r_topy;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_half;
    logic [DEN_W-1:0]  n_dnx;
    logic [DEN_W-1:0]  n_dny;
    logic [PROD_W-1:0] n_prod;

    assign n_dnx  = {r_tgt_w, 1'b0};
    assign n_dny  = {r_tgt_h, 1'b0};
    assign n_prod = PROD_W'(n_dnx) * PROD_W'(n_dny);

    always_ff @(posedge i_clk) begin
        r_sw   <= n_sw;
        r_sh   <= n_sh;
        r_dnx  <= n_dnx;
        r_dny  <= n_dny;
        r_topx <= TXW'(n_sw - SXW'(1)) * TXW'(n_dnx);
        r_topy <= TYW'(n_sh - SYW'(1)) * TYW'(n_dny);
        r_prod <= n_prod;
        r_half <= n_prod >> 1;
    end

    // ---------------------------------------------------------------
    // Pipeline registers and global advance
    // ---------------------------------------------------------------
    t_p1    r_p1;
    t_dv    r_dv [NDIV+1];
    t_pr    r_pr;
    t_pw    r_pw;
    t_ea    r_ea [CH_W+1];
    logic   r_out_vld;
    t_pixel r_out_pix;
    logic   r_out_oor;

    t_p1    n_p1;
    t_dv    n_dv [NDIV+1];
    t_pr    n_pr;
    t_pw    n_pw;
    t_ea    n_ea [CH_W+1];
    logic   n_out_vld;
    t_pixel n_out_pix;

    logic   adv;

    // Advance every stage unless a finished result is held at the output
    assign adv        = !r_out_vld || o_out.ready;
    assign i_in.ready = adv && i_rst_n;

    // Input stage: range checks and the (2d+1)*size products
    always_comb begin
        n_p1.vld  = i_in.valid;
        n_p1.smp  = (i_in.action == ACT_SAMPLE);
        n_p1.oor  = ({1'b0, i_in.dst_col} >= r_tgt_w) || ({1'b0, i_in.dst_row} >= r_tgt_h);
        n_p1.ldok = (int'(i_in.src_col) < int'(n_sw)) && (int'(i_in.src_row) < int'(n_sh));
        n_p1.col  = XP'(i_in.src_col);
        n_p1.row  = YP'(i_in.src_row);
        n_p1.pix  = i_in.src_pixel;
        n_p1.ax   = NXW'({i_in.dst_col, 1'b1}) * NXW'(n_sw);
        n_p1.ay   = NYW'({i_in.dst_row, 1'b1}) * NYW'(n_sh);
    end

    // Clamp the numerators to [0, (size-1)*2*target], then run the division
    // by 2*target, one quotient bit per stage
    logic [NXW-1:0] c_numx;
    logic [NYW-1:0] c_numy;
    logic [DXW-1:0] c_trx [NDIV];
    logic [DYW-1:0] c_try [NDIV];

    always_comb begin
        c_numx = (r_p1.ax > NXW'(r_tgt_w)) ? r_p1.ax - NXW'(r_tgt_w) : '0;
        if (TXW'(c_numx) > r_topx) begin
            c_numx = NXW'(r_topx);
        end
        c_numy = (r_p1.ay > NYW'(r_tgt_h)) ? r_p1.ay - NYW'(r_tgt_h) : '0;
        if (TYW'(c_numy) > r_topy) begin
            c_numy = NYW'(r_topy);
        end

        n_dv[0].vld  = r_p1.vld;
        n_dv[0].smp  = r_p1.smp;
        n_dv[0].oor  = r_p1.oor;
        n_dv[0].ldok = r_p1.ldok;
        n_dv[0].col  = r_p1.col;
        n_dv[0].row  = r_p1.row;
        n_dv[0].pix  = r_p1.pix;
        n_dv[0].remx = c_numx;
        n_dv[0].qx   = '0;
        n_dv[0].remy = c_numy;
        n_dv[0].qy   = '0;

        for (int j = 0; j < NDIV; j++) begin
            c_trx[j]  = DXW'(r_dnx) << (NDIV - 1 - j);
            c_try[j]  = DYW'(r_dny) << (NDIV - 1 - j);
            n_dv[j+1] = r_dv[j];
            if (DXW'(r_dv[j].remx) >= c_trx[j]) begin
                n_dv[j+1].remx              = NXW'(DXW'(r_dv[j].remx) - c_trx[j]);
                n_dv[j+1].qx[NDIV - 1 - j]  = 1'b1;
            end
            if (DYW'(r_dv[j].remy) >= c_try[j]) begin
                n_dv[j+1].remy              = NYW'(DYW'(r_dv[j].remy) - c_try[j]);
                n_dv[j+1].qy[NDIV - 1 - j]  = 1'b1;
            end
        end
    end

    // Memory stage: neighbour indices, bank addresses, load writes
    t_dv              pm;
    t_xc              m_x0;
    t_xc              m_x1;
    t_yc              m_y0;
    t_yc              m_y1;
    logic [XP:0]      m_x0n;
    logic [YP:0]      m_y0n;
    logic [DEN_W-1:0] m_fx;
    logic [DEN_W-1:0] m_fy;
    t_xc              m_cx   [BANK_N];
    t_yc              m_ry   [BANK_N];
    logic [BAW-1:0]   m_addr [BANK_N];
    logic             m_we   [BANK_N];
    t_pixel           bank_q [BANK_N];

    assign pm = r_dv[NDIV];

    always_comb begin
        m_x0  = pm.qx[XP-1:0];
        m_y0  = pm.qy[YP-1:0];
        m_x0n = (XP+1)'(m_x0) + (XP+1)'(1);
        m_y0n = (YP+1)'(m_y0) + (YP+1)'(1);
        // clamp the right and bottom neighbours at the frame edge
        m_x1  = (m_x0n < (XP+1)'(r_sw)) ? m_x0n[XP-1:0] : XP'(r_sw - SXW'(1));
        m_y1  = (m_y0n < (YP+1)'(r_sh)) ? m_y0n[YP-1:0] : YP'(r_sh - SYW'(1));
        m_fx  = pm.remx[DEN_W-1:0];
        m_fy  = pm.remy[DEN_W-1:0];
        for (int b = 0; b < BANK_N; b++) begin
            if (pm.smp) begin
                m_cx[b] = (m_x0[0] == b[0]) ? m_x0 : m_x1;
                m_ry[b] = (m_y0[0] == b[1]) ? m_y0 : m_y1;
            end else begin
                m_cx[b] = pm.col;
                m_ry[b] = pm.row;
            end
            m_addr[b] = {m_ry[b][YP-1:1], m_cx[b][XP-1:1]};
            m_we[b]   = adv && pm.vld && !pm.smp && pm.ldok
                        && (pm.col[0] == b[0]) && (pm.row[0] == b[1]);
        end
    end

    for (genvar g = 0; g < BANK_N; g++) begin : g_bank
        bir_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (m_we[g]),
            .i_waddr (m_addr[g]),
            .i_wdata (pm.pix),
            .i_re    (adv),
            .i_raddr (m_addr[g]),
            .o_rdata (bank_q[g])
        );
    end

    always_comb begin
        n_pr.vld = pm.vld;
        n_pr.smp = pm.smp;
        n_pr.oor = pm.oor;
        n_pr.x0p = m_x0[0];
        n_pr.x1p = m_x1[0];
        n_pr.y0p = m_y0[0];
        n_pr.y1p = m_y1[0];
        n_pr.fx  = m_fx;
        n_pr.fy  = m_fy;
    end

    // Horizontal blend: pick each neighbour from the bank of its parity
    t_pixel           w_p00;
    t_pixel           w_p01;
    t_pixel           w_p10;
    t_pixel           w_p11;
    logic [DEN_W-1:0] w_wx0;

    always_comb begin
        w_p00    = bank_q[{r_pr.y0p, r_pr.x0p}];
        w_p01    = bank_q[{r_pr.y0p, r_pr.x1p}];
        w_p10    = bank_q[{r_pr.y1p, r_pr.x0p}];
        w_p11    = bank_q[{r_pr.y1p, r_pr.x1p}];
        w_wx0    = r_dnx - r_pr.fx;
        n_pw.vld = r_pr.vld;
        n_pw.smp = r_pr.smp;
        n_pw.oor = r_pr.oor;
        n_pw.fy  = r_pr.fy;
        for (int c = 0; c < CH_N; c++) begin
            n_pw.top[c] = TOP_W'(w_p00[c*CH_W +: CH_W]) * TOP_W'(w_wx0)
                        + TOP_W'(w_p01[c*CH_W +: CH_W]) * TOP_W'(r_pr.fx);
            n_pw.bot[c] = TOP_W'(w_p10[c*CH_W +: CH_W]) * TOP_W'(w_wx0)
                        + TOP_W'(w_p11[c*CH_W +: CH_W]) * TOP_W'(r_pr.fx);
        end
    end

    // Vertical blend plus half the denominator, then divide by the full
    // denominator one result bit per stage: this rounds half up
    logic [DEN_W-1:0]  a_wy0;
    logic [ACC_W-1:0]  c_tre [CH_W];

    always_comb begin
        a_wy0       = r_dny - r_pw.fy;
        n_ea[0].vld = r_pw.vld;
        n_ea[0].smp = r_pw.smp;
        n_ea[0].oor = r_pw.oor;
        n_ea[0].q   = '0;
        for (int c = 0; c < CH_N; c++) begin
            n_ea[0].rem[c] = ACC_W'(r_pw.top[c]) * ACC_W'(a_wy0)
                           + ACC_W'(r_pw.bot[c]) * ACC_W'(r_pw.fy)
                           + ACC_W'(r_half);
        end
        for (int j = 0; j < CH_W; j++) begin
            c_tre[j]  = ACC_W'(r_prod) << (CH_W - 1 - j);
            n_ea[j+1] = r_ea[j];
            for (int c = 0; c < CH_N; c++) begin
                if (r_ea[j].rem[c] >= c_tre[j]) begin
                    n_ea[j+1].rem[c]             = r_ea[j].rem[c] - c_tre[j];
                    n_ea[j+1].q[c][CH_W - 1 - j] = 1'b1;
                end
            end
        end
    end

    // Output stage: loads drop out here, out-of-range samples read zero
    assign n_out_vld = r_ea[CH_W].vld && r_ea[CH_W].smp;
    assign n_out_pix = r_ea[CH_W].oor ? '0 : PIX_W'(r_ea[CH_W].q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.vld <= 1'b0;
            for (int k = 0; k <= NDIV; k++) begin
                r_dv[k].vld <= 1'b0;
            end
            r_pr.vld <= 1'b0;
            r_pw.vld <= 1'b0;
            for (int k = 0; k <= CH_W; k++) begin
                r_ea[k].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_p1 <= n_p1;
            for (int k = 0; k <= NDIV; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_pr <= n_pr;
            r_pw <= n_pw;
            for (int k = 0; k <= CH_W; k++) begin
                r_ea[k] <= n_ea[k];
            end
            r_out_vld <= n_out_vld;
            r_out_pix <= n_out_pix;
            r_out_oor <= r_ea[CH_W].oor;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.out_pixel    = r_out_pix;
    assign o_out.out_of_range = r_out_oor;

`ifndef SYNTHESIS
    // The column quotient must land inside the effective source width
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pm.vld && pm.smp && !pm.oor) |-> (int'(m_x0) < int'(r_sw)))
        else $error("column index outside source frame");

    // The remainders must stay below their denominators
    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pm.vld && pm.smp && !pm.oor) |-> ((m_fx < r_dnx) && (m_fy < r_dny)))
        else $error("fraction not below denominator");

    // An out-of-range sample carries a zero pixel
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_of_range) |-> (o_out.out_pixel == '0))
        else $error("out-of-range result with non-zero pixel");
`endif

endmodule
